FILE: rtl/sqlp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlp_pkg
// Shared types and constants for the step sequencer with note looper:
// payload structs, configuration layout and register indexes.
// ----------------------------------------------------------------------------
package sqlp_pkg;

  // sequencer geometry
  localparam int MAX_STEPS = 32;
  localparam int STEP_W    = $clog2(MAX_STEPS);
  localparam int LEN_W     = 6;
  localparam int PAT_W     = 32;
  localparam int PAT_IDX_W = $clog2(PAT_W);
  localparam int NOTE_W    = 3;
  localparam int NOTE_MAX  = 5;
  localparam int STEP_OUT_W = 5;

  // configuration port
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_IDX_LOOP_STEPS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_KICK_PATTERN  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_SNARE_PATTERN = 2'd2;

  // register reset values
  localparam logic [LEN_W-1:0] LOOP_STEPS_RST    = 6'd32;
  localparam logic [PAT_W-1:0] KICK_PATTERN_RST  = 32'hAAAA_AAAA;
  localparam logic [PAT_W-1:0] SNARE_PATTERN_RST = 32'h8888_8888;

  // input transaction
  typedef struct packed {
    logic              beat_tick;
    logic [NOTE_W-1:0] button_note;
    logic              record_press;
  } sqlp_in_t;

  // result transaction
  typedef struct packed {
    logic [NOTE_W-1:0]     note_out;
    logic [STEP_OUT_W-1:0] step_now;
    logic                  is_recording;
    logic                  kick_hit;
    logic                  snare_hit;
  } sqlp_out_t;

  // configuration register set
  typedef struct packed {
    logic [LEN_W-1:0] loop_steps;
    logic [PAT_W-1:0] kick_pattern;
    logic [PAT_W-1:0] snare_pattern;
  } sqlp_cfg_t;

endpackage

FILE: rtl/sqlp_cfg_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlp_cfg_regs
// Configuration registers: loop length and the kick and snare patterns,
// written through a plain indexed write port.
// ----------------------------------------------------------------------------
module sqlp_cfg_regs
  import sqlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output sqlp_cfg_t             cfg
);

  sqlp_cfg_t cfg_r;

  // register write decode, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.loop_steps    <= LOOP_STEPS_RST;
      cfg_r.kick_pattern  <= KICK_PATTERN_RST;
      cfg_r.snare_pattern <= SNARE_PATTERN_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_IDX_LOOP_STEPS:    cfg_r.loop_steps    <= cfg_data[LEN_W-1:0];
        CFG_IDX_KICK_PATTERN:  cfg_r.kick_pattern  <= cfg_data[PAT_W-1:0];
        CFG_IDX_SNARE_PATTERN: cfg_r.snare_pattern <= cfg_data[PAT_W-1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

FILE: rtl/sqlp_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlp_core
// Sequencer state and per-transaction logic: step counter, record mode,
// per-step note store, note resolution and drum hits.
// ----------------------------------------------------------------------------
module sqlp_core
  import sqlp_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  sqlp_in_t  item,
  input  sqlp_cfg_t cfg,
  output sqlp_out_t result
);

  logic [STEP_W-1:0] step_r;
  logic [STEP_W-1:0] step_nxt;
  logic              rec_r;
  logic              rec_nxt;
  logic [NOTE_W-1:0] notes_r [MAX_STEPS];

  logic [NOTE_W-1:0] note;
  logic [LEN_W-1:0]  len;
  logic [LEN_W-1:0]  last_step;
  logic              clear;
  logic [NOTE_W-1:0] stored;
  logic              play;
  logic              wr_en;

  // pattern bit lookup, steps past the pattern width never hit
  function automatic logic pattern_bit(input logic [PAT_W-1:0] pat,
                                       input logic [STEP_W-1:0] idx);
    logic hit;
    hit = 1'b0;
    if (32'(idx) < PAT_W) hit = pat[PAT_IDX_W'(idx)];
    return hit;
  endfunction

  // effective loop length and step advance
  always_comb begin
    note = (item.button_note > NOTE_W'(NOTE_MAX)) ? '0 : item.button_note;
    if (cfg.loop_steps == '0) begin
      len = LEN_W'(1);
    end else if (cfg.loop_steps > LEN_W'(MAX_STEPS)) begin
      len = LEN_W'(MAX_STEPS);
    end else begin
      len = cfg.loop_steps;
    end
    last_step = len - LEN_W'(1);
    step_nxt  = step_r;
    if (item.beat_tick) begin
      step_nxt = (LEN_W'(step_r) < last_step) ? step_r + STEP_W'(1) : '0;
    end
  end

  // record toggle, looper playback and record
  always_comb begin
    clear   = item.record_press && rec_r;
    rec_nxt = item.record_press ? !rec_r : rec_r;
    stored  = clear ? '0 : notes_r[step_nxt];
    play    = (note == '0) && (stored != '0);
    wr_en   = !play && (note != '0) && rec_nxt;

    result.note_out     = play ? stored : note;
    result.step_now     = STEP_OUT_W'(step_nxt);
    result.is_recording = rec_nxt;
    result.kick_hit     = item.beat_tick && pattern_bit(cfg.kick_pattern, step_nxt);
    result.snare_hit    = item.beat_tick && pattern_bit(cfg.snare_pattern, step_nxt);
  end

  // state update on each transaction
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_W'(MAX_STEPS - 1);
      rec_r  <= 1'b0;
      for (int i = 0; i < MAX_STEPS; i++) begin
        notes_r[i] <= '0;
      end
    end else if (fire) begin
      step_r <= step_nxt;
      rec_r  <= rec_nxt;
      if (clear) begin
        for (int i = 0; i < MAX_STEPS; i++) begin
          notes_r[i] <= '0;
        end
      end else if (wr_en) begin
        notes_r[step_nxt] <= note;
      end
    end
  end

endmodule

FILE: rtl/step_sequencer_note_looper.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// step_sequencer_note_looper
// Step sequencer with a one-note-per-step looper, one transaction per audio
// sample. A beat tick advances the step counter, which wraps after the
// configured loop length; a record press toggles recording and stopping a
// recording clears every stored note. With no button held the note stored at
// the current step plays back; while recording a held note is stored there.
// Kick and snare hit on a tick when the pattern bit of the new step is set.
// Each transaction passes an input register and then a result register, and
// one transaction is taken every clock cycle while the input does not stall;
// the step and note state is updated as the transaction leaves the input
// register. Input stalls only while a result is held by out_stall with the
// input register full. No clearing pass after reset: the note store is
// cleared by reset directly.
// ----------------------------------------------------------------------------
module step_sequencer_note_looper
  import sqlp_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  sqlp_in_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output sqlp_out_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  sqlp_cfg_t cfg;
  sqlp_out_t result;

  logic      s1_valid_r;
  sqlp_in_t  s1_data_r;
  logic      out_valid_r;
  sqlp_out_t out_data_r;
  logic      s1_adv;
  logic      fire;

  sqlp_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  sqlp_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .fire   (fire),
    .item   (s1_data_r),
    .cfg    (cfg),
    .result (result)
  );

  // flow control between the two registers
  assign s1_adv   = !out_valid_r || !out_stall;
  assign fire     = s1_valid_r && s1_adv;
  assign in_stall = s1_valid_r && !s1_adv;

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid_r <= 1'b1;
    end else if (fire) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_data_r <= in_data;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/sqlp_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sqlp_checker
// Port-level checks for the step sequencer with note looper, bound to the
// top level.
// ----------------------------------------------------------------------------
module sqlp_checker
  import sqlp_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input sqlp_in_t  in_data,
  input logic      out_valid,
  input logic      out_stall,
  input sqlp_out_t out_data
);

  // no result comes out of reset
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // input only backs up behind a held result
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled while result side is free");

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_stall) |=> (in_valid && $stable(in_data)))
    else $error("stalled input changed");

  // resolved note is always a legal scale degree or silence
  a_note_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.note_out <= NOTE_W'(NOTE_MAX)))
    else $error("note out of range");

  // a stalled result transaction holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed");

endmodule

bind step_sequencer_note_looper sqlp_checker u_sqlp_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
